// ----- rtl/cta_pkg.sv -----
package cta_pkg;

  localparam int unsigned MaxVertices    = 1024;
  localparam int unsigned MaxCommunities = 1024;
  localparam int unsigned WeightBits     = 32;
  localparam int unsigned CntW           = 11;
  localparam int unsigned VcW            = 11;
  localparam int unsigned IdxW           = 10;
  localparam int unsigned InWW           = 31;
  localparam int unsigned OutWW          = 32;

  typedef enum logic [1:0] {
    FUNC_ASSIGN   = 2'd0,
    FUNC_MOVE     = 2'd1,
    FUNC_RENUMBER = 2'd2,
    FUNC_NOP      = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_WR,
    S_M_MEM,
    S_M_OLD,
    S_M_NEW,
    S_R_RD,
    S_R_WR,
    S_R_CLR,
    S_R_VRD,
    S_R_VMAP,
    S_R_VWR,
    S_DONE
  } state_e;

endpackage

// ----- rtl/community_tally_table.sv -----
// Community tally table. One item is a command: assign a vertex to a community,
// move a vertex between communities, or renumber all communities densely. Each
// transfer on the input channel yields exactly one result transfer. The state
// lives in two memories, each with one read port, one write port and a
// registered read. The record memory holds the community records (member
// count, total weight, inner weight). The id memory keeps vertex membership in
// its lower half and the renumber map in its upper half; no state touches both
// halves in the same cycle. An assign makes one record read and one
// write-back before its result. A move reads the membership, then does a
// read-modify-write of the old record and one of the target record, with the
// target read forwarded when both records are the same. An out-of-range
// command or the unused code goes straight to its result. A renumber reads the
// record of every id below the id count U and writes its map entry, then clears
// the records from the new count N up to MAX_COMMUNITIES one per cycle, then
// remaps every vertex below the vertex count V by a membership read, a map
// lookup and a write-back. After reset the record memory is cleared one entry
// per cycle, so no command is taken until that clear is done; vertex_count
// writes are taken at any time. Weights are Q16.16 and wrap.
module community_tally_table
  import cta_pkg::*;
#(
  parameter int unsigned MAX_VERTICES    = MaxVertices,
  parameter int unsigned MAX_COMMUNITIES = MaxCommunities,
  parameter int unsigned WEIGHT_BITS     = WeightBits
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [VcW-1:0]          cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic [IdxW-1:0]         vertex_i,
  input  logic [IdxW-1:0]         target_community_i,
  input  logic [InWW-1:0]         vertex_weight_i,
  input  logic [InWW-1:0]         self_loop_weight_i,
  input  logic [InWW-1:0]         old_links_weight_i,
  input  logic [InWW-1:0]         new_links_weight_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [IdxW-1:0]         previous_community_o,
  output logic [CntW-1:0]         previous_size_o,
  output logic signed [OutWW-1:0] previous_total_o,
  output logic signed [OutWW-1:0] previous_inner_o,
  output logic [CntW-1:0]         target_size_o,
  output logic signed [OutWW-1:0] target_total_o,
  output logic signed [OutWW-1:0] target_inner_o,
  output logic [CntW-1:0]         community_count_o,
  output logic                    range_error_o
);

  localparam int unsigned W     = WEIGHT_BITS;
  localparam int unsigned CIDX  = $clog2(MAX_COMMUNITIES);
  localparam int unsigned VIDX  = $clog2(MAX_VERTICES);
  localparam int unsigned IDW   = (VIDX > CIDX) ? VIDX : CIDX;
  localparam int unsigned RECW  = CntW + 2 * W;
  localparam int unsigned KMAX  = (MAX_VERTICES > MAX_COMMUNITIES) ?
                                  MAX_VERTICES : MAX_COMMUNITIES;
  localparam int unsigned KW    = $clog2(KMAX + 1);
  localparam int unsigned UW    = $clog2(MAX_COMMUNITIES + 1);

  state_e state_q, state_d;

  // Control registers.
  logic           out_valid_q, out_valid_d;
  logic [UW-1:0]  used_q, used_d;
  logic [VcW-1:0] vc_q;
  logic [KW-1:0]  k_q, k_d;
  logic [UW-1:0]  n_q, n_d;

  // Payload registers.
  logic [IdxW-1:0] v_q, v_d, c_q, c_d;
  logic [W-1:0]    w_q, w_d, self_q, self_d, oldl_q, oldl_d, newl_q, newl_d;
  logic [CIDX-1:0] old_q, old_d, m_q, m_d;
  logic [CntW-1:0] ocnt_q, ocnt_d;
  logic [W-1:0]    otot_q, otot_d, oinn_q, oinn_d;

  logic [IdxW-1:0] res_pc_q, res_pc_d;
  logic [CntW-1:0] res_ps_q, res_ps_d, res_ts_q, res_ts_d;
  logic [W-1:0]    res_pt_q, res_pt_d, res_pi_q, res_pi_d;
  logic [W-1:0]    res_tt_q, res_tt_d, res_ti_q, res_ti_d;
  logic            res_err_q, res_err_d;

  logic [IdxW-1:0] out_pc_q, out_pc_d;
  logic [CntW-1:0] out_ps_q, out_ps_d, out_ts_q, out_ts_d, out_cc_q, out_cc_d;
  logic [W-1:0]    out_pt_q, out_pt_d, out_pi_q, out_pi_d;
  logic [W-1:0]    out_tt_q, out_tt_d, out_ti_q, out_ti_d;
  logic            out_err_q, out_err_d;

  // Memory ports.
  logic            rec_we, mem_we, map_we;
  logic [CIDX-1:0] rec_waddr, rec_raddr, map_waddr, map_raddr;
  logic [VIDX-1:0] mem_waddr, mem_raddr;
  logic [RECW-1:0] rec_wdata, rec_rdata;
  logic [CIDX-1:0] mem_wdata, mem_rdata, map_wdata, map_rdata;
  logic            id_we;
  logic [IDW:0]    id_waddr, id_raddr;
  logic [CIDX-1:0] id_wdata, id_rdata;

  logic [CntW-1:0] rd_cnt, b_cnt, t_cnt;
  logic [W-1:0]    rd_tot, rd_inn, b_tot, b_inn, t_tot, t_inn;
  logic            in_xfer, out_free, v_bad, k_in_v;

  cta_ram #(.DataW(RECW), .Depth(MAX_COMMUNITIES)) u_rec (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );

  cta_ram #(.DataW(CIDX), .Depth(2 << IDW)) u_ids (
    .clk_i, .we_i(id_we), .waddr_i(id_waddr), .wdata_i(id_wdata),
    .raddr_i(id_raddr), .rdata_o(id_rdata)
  );

  // Membership sits in the lower half of the id memory and the renumber map in
  // the upper half. Only the map lookup of the vertex walk reads the upper half.
  assign id_we     = mem_we || map_we;
  assign id_waddr  = map_we ? {1'b1, IDW'(map_waddr)} : {1'b0, IDW'(mem_waddr)};
  assign id_wdata  = map_we ? map_wdata : mem_wdata;
  assign id_raddr  = (state_q == S_R_VMAP) ? {1'b1, IDW'(map_raddr)} :
                                             {1'b0, IDW'(mem_raddr)};
  assign mem_rdata = id_rdata;
  assign map_rdata = id_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign rd_cnt = rec_rdata[RECW-1 -: CntW];
  assign rd_tot = rec_rdata[2*W-1 -: W];
  assign rd_inn = rec_rdata[W-1:0];

  // The target read of a move sees the freshly updated old record when both match.
  assign b_cnt = (CIDX'(c_q) == old_q) ? ocnt_q : rd_cnt;
  assign b_tot = (CIDX'(c_q) == old_q) ? otot_q : rd_tot;
  assign b_inn = (CIDX'(c_q) == old_q) ? oinn_q : rd_inn;

  assign v_bad  = (32'(vertex_i) >= 32'(vc_q)) || (32'(vertex_i) >= MAX_VERTICES);
  assign k_in_v = (32'(k_q) < 32'(vc_q)) && (32'(k_q) < MAX_VERTICES);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (32'(k_q) == MAX_COMMUNITIES - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (func_i)
            FUNC_ASSIGN: begin
              state_d = (v_bad || 32'(target_community_i) >= MAX_COMMUNITIES) ?
                        S_DONE : S_A_WR;
            end
            FUNC_MOVE: begin
              state_d = (v_bad || UW'(target_community_i) >= used_q ||
                         32'(target_community_i) >= MAX_COMMUNITIES) ?
                        S_DONE : S_M_MEM;
            end
            FUNC_RENUMBER: state_d = S_R_RD;
            default:       state_d = S_DONE;
          endcase
        end
      end
      S_A_WR:   state_d = S_DONE;
      S_M_MEM:  state_d = S_M_OLD;
      S_M_OLD:  state_d = S_M_NEW;
      S_M_NEW:  state_d = S_DONE;
      S_R_RD:   state_d = (UW'(k_q) < used_q) ? S_R_WR : S_R_CLR;
      S_R_WR:   state_d = S_R_RD;
      S_R_CLR:  state_d = (32'(k_q) < MAX_COMMUNITIES) ? S_R_CLR : S_R_VRD;
      S_R_VRD:  state_d = k_in_v ? S_R_VMAP : S_DONE;
      S_R_VMAP: state_d = S_R_VWR;
      S_R_VWR:  state_d = S_R_VRD;
      S_DONE:   state_d = out_free ? S_IDLE : S_DONE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    out_valid_d = out_valid_q;
    used_d = used_q;
    k_d = k_q;
    n_d = n_q;
    v_d = v_q; c_d = c_q;
    w_d = w_q; self_d = self_q; oldl_d = oldl_q; newl_d = newl_q;
    old_d = old_q; m_d = m_q;
    ocnt_d = ocnt_q; otot_d = otot_q; oinn_d = oinn_q;
    res_pc_d = res_pc_q; res_ps_d = res_ps_q; res_pt_d = res_pt_q; res_pi_d = res_pi_q;
    res_ts_d = res_ts_q; res_tt_d = res_tt_q; res_ti_d = res_ti_q; res_err_d = res_err_q;
    out_pc_d = out_pc_q; out_ps_d = out_ps_q; out_pt_d = out_pt_q; out_pi_d = out_pi_q;
    out_ts_d = out_ts_q; out_tt_d = out_tt_q; out_ti_d = out_ti_q;
    out_cc_d = out_cc_q; out_err_d = out_err_q;
    rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0; rec_raddr = '0;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
    map_we = 1'b0; map_waddr = '0; map_wdata = '0; map_raddr = '0;
    t_cnt = '0; t_tot = '0; t_inn = '0;

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      S_CLEAR: begin
        rec_we    = 1'b1;
        rec_waddr = k_q[CIDX-1:0];
        k_d       = (32'(k_q) == MAX_COMMUNITIES - 1) ? '0 : k_q + 1'b1;
      end
      S_IDLE: begin
        if (in_xfer) begin
          v_d = vertex_i; c_d = target_community_i;
          w_d = W'(vertex_weight_i); self_d = W'(self_loop_weight_i);
          oldl_d = W'(old_links_weight_i); newl_d = W'(new_links_weight_i);
          res_pc_d = '0; res_ps_d = '0; res_pt_d = '0; res_pi_d = '0;
          res_ts_d = '0; res_tt_d = '0; res_ti_d = '0;
          res_err_d = ((func_i == FUNC_ASSIGN || func_i == FUNC_MOVE) &&
                       (state_d == S_DONE));
          rec_raddr = CIDX'(target_community_i);
          mem_raddr = VIDX'(vertex_i);
          k_d = '0;
          n_d = '0;
        end
      end
      S_A_WR: begin
        t_cnt = rd_cnt + 1'b1;
        t_tot = rd_tot + w_q;
        t_inn = rd_inn + self_q;
        rec_we = 1'b1; rec_waddr = CIDX'(c_q); rec_wdata = {t_cnt, t_tot, t_inn};
        mem_we = 1'b1; mem_waddr = VIDX'(v_q); mem_wdata = CIDX'(c_q);
        if (UW'(c_q) + 1'b1 > used_q) used_d = UW'(c_q) + 1'b1;
        res_ts_d = t_cnt; res_tt_d = t_tot; res_ti_d = t_inn;
      end
      S_M_MEM: begin
        old_d     = mem_rdata;
        rec_raddr = mem_rdata;
      end
      S_M_OLD: begin
        ocnt_d = rd_cnt - 1'b1;
        otot_d = rd_tot - w_q;
        oinn_d = rd_inn - ((oldl_q << 1) + self_q);
        rec_we = 1'b1; rec_waddr = old_q; rec_wdata = {ocnt_d, otot_d, oinn_d};
        rec_raddr = CIDX'(c_q);
      end
      S_M_NEW: begin
        t_cnt = b_cnt + 1'b1;
        t_tot = b_tot + w_q;
        t_inn = b_inn + ((newl_q << 1) + self_q);
        rec_we = 1'b1; rec_waddr = CIDX'(c_q); rec_wdata = {t_cnt, t_tot, t_inn};
        mem_we = 1'b1; mem_waddr = VIDX'(v_q); mem_wdata = CIDX'(c_q);
        res_pc_d = IdxW'(old_q);
        res_ps_d = (CIDX'(c_q) == old_q) ? t_cnt : ocnt_q;
        res_pt_d = (CIDX'(c_q) == old_q) ? t_tot : otot_q;
        res_pi_d = (CIDX'(c_q) == old_q) ? t_inn : oinn_q;
        res_ts_d = t_cnt; res_tt_d = t_tot; res_ti_d = t_inn;
      end
      S_R_RD: begin
        rec_raddr = k_q[CIDX-1:0];
        if (UW'(k_q) >= used_q) k_d = KW'(n_q);
      end
      S_R_WR: begin
        map_we    = 1'b1;
        map_waddr = k_q[CIDX-1:0];
        if (rd_cnt != '0) begin
          rec_we = 1'b1; rec_waddr = n_q[CIDX-1:0]; rec_wdata = rec_rdata;
          map_wdata = n_q[CIDX-1:0];
          n_d = n_q + 1'b1;
        end
        k_d = k_q + 1'b1;
      end
      S_R_CLR: begin
        if (32'(k_q) < MAX_COMMUNITIES) begin
          rec_we = 1'b1; rec_waddr = k_q[CIDX-1:0];
          k_d = k_q + 1'b1;
        end else begin
          k_d = '0;
        end
      end
      S_R_VRD: begin
        mem_raddr = k_q[VIDX-1:0];
        if (!k_in_v) used_d = n_q;
      end
      S_R_VMAP: begin
        m_d       = mem_rdata;
        map_raddr = mem_rdata;
      end
      S_R_VWR: begin
        mem_we    = 1'b1;
        mem_waddr = k_q[VIDX-1:0];
        mem_wdata = (UW'(m_q) < used_q) ? map_rdata : '0;
        k_d       = k_q + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pc_d = res_pc_q; out_ps_d = res_ps_q; out_pt_d = res_pt_q;
          out_pi_d = res_pi_q; out_ts_d = res_ts_q; out_tt_d = res_tt_q;
          out_ti_d = res_ti_q; out_err_d = res_err_q;
          out_cc_d = CntW'(used_q);
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      vc_q        <= VcW'(MaxVertices);
      k_q         <= '0;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      used_q      <= used_d;
      k_q         <= k_d;
      n_q         <= n_d;
      if (cfg_we_i) vc_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d; c_q <= c_d;
    w_q <= w_d; self_q <= self_d; oldl_q <= oldl_d; newl_q <= newl_d;
    old_q <= old_d; m_q <= m_d;
    ocnt_q <= ocnt_d; otot_q <= otot_d; oinn_q <= oinn_d;
    res_pc_q <= res_pc_d; res_ps_q <= res_ps_d; res_pt_q <= res_pt_d;
    res_pi_q <= res_pi_d; res_ts_q <= res_ts_d; res_tt_q <= res_tt_d;
    res_ti_q <= res_ti_d; res_err_q <= res_err_d;
    out_pc_q <= out_pc_d; out_ps_q <= out_ps_d; out_pt_q <= out_pt_d;
    out_pi_q <= out_pi_d; out_ts_q <= out_ts_d; out_tt_q <= out_tt_d;
    out_ti_q <= out_ti_d; out_cc_q <= out_cc_d; out_err_q <= out_err_d;
  end

  assign out_valid_o          = out_valid_q;
  assign previous_community_o = out_pc_q;
  assign previous_size_o      = out_ps_q;
  assign previous_total_o     = OutWW'(signed'(out_pt_q));
  assign previous_inner_o     = OutWW'(signed'(out_pi_q));
  assign target_size_o        = out_ts_q;
  assign target_total_o       = OutWW'(signed'(out_tt_q));
  assign target_inner_o       = OutWW'(signed'(out_ti_q));
  assign community_count_o    = out_cc_q;
  assign range_error_o        = out_err_q;

  // The id count never exceeds the number of community records.
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= MAX_COMMUNITIES)
    else $error("community id count beyond record depth");

  // A new result only ever comes out of the completion state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion");

  // A rejected command reports a zero previous community and zero target fields.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_err_q) |-> (out_pc_q == '0 && out_ts_q == '0 &&
                                     out_tt_q == '0 && out_ti_q == '0))
    else $error("range error with nonzero fields");

  // Commands are only taken once the post-reset record clear has finished.
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("command taken during record clear");

endmodule

// ----- rtl/cta_ram.sv -----
module cta_ram
  import cta_pkg::*;
#(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [DataW-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [DataW-1:0]         rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Read returns the old contents when the same entry is written in that cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
